[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the trigger
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ffsa_pkg.sv]
package ffsa_pkg;

	localparam logic [1:0] OP_ALLOC    = 2'd0;
	localparam logic [1:0] OP_RELEASE  = 2'd1;
	localparam logic [1:0] OP_COALESCE = 2'd2;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_NO_FIT    = 3'd1;
	localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
	localparam logic [2:0] ST_NO_OWNER  = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	localparam logic [7:0]  FREE_TAG   = 8'd63;
	localparam logic [15:0] POOL_RESET = 16'd1000;

	typedef struct packed {
		logic       capture;
		logic       cfg_load;
		logic       scan_start;
		logic       scan_rd;
		logic       scan_next;
		logic       shift_start;
		logic       shift_rd;
		logic       shift_wr;
		logic       wr_left;
		logic       wr_seg;
		logic       wr_free;
		logic       co_start;
		logic       co_rd;
		logic       co_ck;
		logic       co_end;
		logic       result_load;
		logic [2:0] result_status;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       req_zero;
		logic       fit;
		logic       left_zero;
		logic       match;
		logic       scan_last;
		logic       table_full;
		logic       shift_more;
		logic       co_more;
	} dp_sts_t;

endpackage

[sv/ffsa_ctrl.sv]
`include "assert_macros.svh"

module ffsa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	output logic               result_valid,
	input  logic               result_stall,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  ffsa_pkg::dp_sts_t  sts,
	output ffsa_pkg::dp_cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_START    = 11'b000_0000_0010,
		S_SCAN_RD  = 11'b000_0000_0100,
		S_SCAN_CK  = 11'b000_0000_1000,
		S_SHIFT_RD = 11'b000_0001_0000,
		S_SHIFT_WR = 11'b000_0010_0000,
		S_WR_SEG   = 11'b000_0100_0000,
		S_CO_RD    = 11'b000_1000_0000,
		S_CO_CK    = 11'b001_0000_0000,
		S_CO_END   = 11'b010_0000_0000,
		S_FIN      = 11'b100_0000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] code_q, code_d;
	logic       result_valid_q;
	logic       slot_free;

	assign slot_free    = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign cfg_ready    = (state_q == S_IDLE);
	assign item_stall   = (state_q != S_IDLE) || cfg_valid;

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.result_status = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (cfg_valid) begin
					cmd.cfg_load = 1'b1;
				end else if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_START;
				end
			end
			S_START: begin
				if (sts.op == ffsa_pkg::OP_ALLOC && sts.req_zero) begin
					code_d  = ffsa_pkg::ST_ZERO_SIZE;
					state_d = S_FIN;
				end else if (sts.op == ffsa_pkg::OP_ALLOC || sts.op == ffsa_pkg::OP_RELEASE) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN_RD;
				end else if (sts.op == ffsa_pkg::OP_COALESCE) begin
					cmd.co_start = 1'b1;
					state_d      = S_CO_RD;
				end else begin
					code_d  = ffsa_pkg::ST_DONE;
					state_d = S_FIN;
				end
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_CK;
			end
			S_SCAN_CK: begin
				if (sts.op == ffsa_pkg::OP_ALLOC) begin
					priority if (sts.fit && sts.left_zero) begin
						cmd.wr_seg = 1'b1;
						code_d     = ffsa_pkg::ST_DONE;
						state_d    = S_FIN;
					end else if (sts.fit && sts.table_full) begin
						code_d  = ffsa_pkg::ST_FULL;
						state_d = S_FIN;
					end else if (sts.fit) begin
						cmd.shift_start = 1'b1;
						state_d         = S_SHIFT_RD;
					end else if (sts.scan_last) begin
						code_d  = ffsa_pkg::ST_NO_FIT;
						state_d = S_FIN;
					end else begin
						cmd.scan_next = 1'b1;
						state_d       = S_SCAN_RD;
					end
				end else begin
					priority if (sts.match) begin
						cmd.wr_free = 1'b1;
						code_d      = ffsa_pkg::ST_DONE;
						state_d     = S_FIN;
					end else if (sts.scan_last) begin
						code_d  = ffsa_pkg::ST_NO_OWNER;
						state_d = S_FIN;
					end else begin
						cmd.scan_next = 1'b1;
						state_d       = S_SCAN_RD;
					end
				end
			end
			S_SHIFT_RD: begin
				if (sts.shift_more) begin
					cmd.shift_rd = 1'b1;
					state_d      = S_SHIFT_WR;
				end else begin
					cmd.wr_left = 1'b1;
					state_d     = S_WR_SEG;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_WR_SEG: begin
				cmd.wr_seg = 1'b1;
				code_d     = ffsa_pkg::ST_DONE;
				state_d    = S_FIN;
			end
			S_CO_RD: begin
				cmd.co_rd = 1'b1;
				state_d   = S_CO_CK;
			end
			S_CO_CK: begin
				cmd.co_ck = 1'b1;
				state_d   = sts.co_more ? S_CO_RD : S_CO_END;
			end
			S_CO_END: begin
				cmd.co_end = 1'b1;
				code_d     = ffsa_pkg::ST_DONE;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			code_q         <= ffsa_pkg::ST_DONE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (cmd.result_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, !cfg_ready, "item transfer did not leave idle")
	`ASSERT_ALWAYS(a_cfg_excludes_item, !(cfg_valid && cfg_ready && item_valid && !item_stall), "config and item transfer together")
	`ASSERT_IMPL(a_load_into_free_slot, cmd.result_load, slot_free, "result loaded over a stalled result")

endmodule

[sv/ffsa_dp.sv]
`include "assert_macros.svh"

module ffsa_dp #(
	parameter int MAX_SEGMENTS = 16,
	parameter int SIZE_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ffsa_pkg::dp_cmd_t  cmd,
	output ffsa_pkg::dp_sts_t  sts,
	input  logic [1:0]         operation,
	input  logic [7:0]         owner_tag,
	input  logic [15:0]        request_size,
	input  logic [15:0]        cfg_data,
	output logic [2:0]         status,
	output logic [3:0]         segment_index
);

	localparam int IW   = $clog2(MAX_SEGMENTS);
	localparam int CW   = $clog2(MAX_SEGMENTS + 1);
	localparam int EW   = SIZE_BITS + 9;
	localparam int CMPW = (SIZE_BITS > 16) ? SIZE_BITS : 16;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	logic [EW-1:0]        mem [MAX_SEGMENTS];
	logic [EW-1:0]        raw_s1;
	logic                 init_s1;
	logic [EW-1:0]        rdata;

	logic [1:0]           op_q;
	logic [7:0]           tag_q;
	logic [15:0]          req_q;
	logic [SIZE_BITS-1:0] pool_q;
	logic                 init_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        i_q, j_q, r_q, w_q;
	logic [SIZE_BITS-1:0] left_q;
	logic [EW-1:0]        acc_q;
	logic [2:0]           status_q;
	logic [3:0]           index_q;

	logic                 rd_en;
	logic [IW-1:0]        raddr;
	logic                 we;
	logic [IW-1:0]        waddr;
	logic [EW-1:0]        wdata;

	logic                 rd_used;
	logic [7:0]           rd_owner;
	logic [SIZE_BITS-1:0] rd_size;
	logic [CMPW-1:0]      size_ext, req_ext, diff_ext;
	logic [CW-1:0]        ip1, jm1, rp1;
	logic                 co_merge;
	logic [IW-1:0]        idx_sel;
	logic [IW+3:0]        idx_ext;

	assign rdata    = init_s1 ? {1'b0, 8'd0, pool_q} : raw_s1;
	assign rd_used  = rdata[EW-1];
	assign rd_owner = rdata[EW-2 -: 8];
	assign rd_size  = rdata[SIZE_BITS-1:0];
	assign size_ext = CMPW'(rd_size);
	assign req_ext  = CMPW'(req_q);
	assign diff_ext = size_ext - req_ext;
	assign ip1      = i_q + CNT_ONE;
	assign jm1      = j_q - CNT_ONE;
	assign rp1      = r_q + CNT_ONE;
	assign co_merge = !acc_q[EW-1] && !rd_used;

	assign sts.op         = op_q;
	assign sts.req_zero   = (req_q == 16'd0);
	assign sts.fit        = !rd_used && (size_ext >= req_ext);
	assign sts.left_zero  = (size_ext == req_ext);
	assign sts.match      = rd_used && (rd_owner == tag_q);
	assign sts.scan_last  = (ip1 == count_q);
	assign sts.table_full = (count_q == CNT_MAX);
	assign sts.shift_more = (j_q > ip1);
	assign sts.co_more    = (rp1 < count_q);

	assign rd_en = cmd.scan_rd || cmd.shift_rd || cmd.co_rd;

	always_comb begin
		priority if (cmd.shift_rd) begin
			raddr = jm1[IW-1:0];
		end else if (cmd.co_rd) begin
			raddr = r_q[IW-1:0];
		end else begin
			raddr = i_q[IW-1:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = i_q[IW-1:0];
		wdata = rdata;
		priority if (cmd.shift_wr) begin
			we    = 1'b1;
			waddr = j_q[IW-1:0];
			wdata = rdata;
		end else if (cmd.wr_left) begin
			we    = 1'b1;
			waddr = ip1[IW-1:0];
			wdata = {1'b0, ffsa_pkg::FREE_TAG, left_q};
		end else if (cmd.wr_seg) begin
			we    = 1'b1;
			waddr = i_q[IW-1:0];
			wdata = {1'b1, tag_q, req_ext[SIZE_BITS-1:0]};
		end else if (cmd.wr_free) begin
			we    = 1'b1;
			waddr = i_q[IW-1:0];
			wdata = {1'b0, ffsa_pkg::FREE_TAG, rd_size};
		end else if ((cmd.co_ck && r_q != '0 && !co_merge) || cmd.co_end) begin
			we    = 1'b1;
			waddr = w_q[IW-1:0];
			wdata = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			raw_s1  <= mem[raddr];
			init_s1 <= init_q && (raddr == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q  <= SIZE_BITS'(ffsa_pkg::POOL_RESET);
			init_q  <= 1'b1;
			count_q <= CNT_ONE;
		end else begin
			if (cmd.cfg_load) begin
				pool_q  <= SIZE_BITS'(cfg_data);
				init_q  <= 1'b1;
				count_q <= CNT_ONE;
			end else begin
				if (we && waddr == '0) begin
					init_q <= 1'b0;
				end
				if (cmd.wr_left) begin
					count_q <= count_q + CNT_ONE;
				end else if (cmd.co_end) begin
					count_q <= w_q + CNT_ONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			tag_q <= owner_tag;
			req_q <= request_size;
		end
		if (cmd.scan_start) begin
			i_q <= '0;
		end else if (cmd.scan_next) begin
			i_q <= ip1;
		end
		if (cmd.shift_start) begin
			j_q    <= count_q;
			left_q <= diff_ext[SIZE_BITS-1:0];
		end else if (cmd.shift_wr) begin
			j_q <= jm1;
		end
		if (cmd.co_start) begin
			r_q <= '0;
			w_q <= '0;
		end else if (cmd.co_ck) begin
			r_q <= rp1;
			if (r_q == '0) begin
				acc_q <= rdata;
			end else if (co_merge) begin
				acc_q[SIZE_BITS-1:0] <= acc_q[SIZE_BITS-1:0] + rd_size;
			end else begin
				acc_q <= rdata;
				w_q   <= w_q + CNT_ONE;
			end
		end
		if (cmd.result_load) begin
			status_q <= cmd.result_status;
			index_q  <= idx_ext[3:0];
		end
	end

	always_comb begin
		if (cmd.result_status == ffsa_pkg::ST_DONE &&
			(op_q == ffsa_pkg::OP_ALLOC || op_q == ffsa_pkg::OP_RELEASE)) begin
			idx_sel = i_q[IW-1:0];
		end else begin
			idx_sel = '0;
		end
	end

	assign idx_ext       = {4'b0000, idx_sel};
	assign status        = status_q;
	assign segment_index = index_q;

	`ASSERT_ALWAYS(a_count_range, (count_q != '0) && (count_q <= CNT_MAX), "segment count out of range")
	`ASSERT_IMPL(a_write_in_table, we, CW'(waddr) <= count_q, "write beyond end of table")
	`ASSERT_IMPL(a_scan_in_table, cmd.scan_rd, i_q < count_q, "scan beyond end of table")

endmodule

[sv/first_fit_segment_allocator_top.sv]
// operation: allocate scans segments for the first free one that fits and splits off any leftover
// by moving later entries up; zero size and unused operation codes go straight to the result
// release scans for the owner's segment and frees it, coalesce merges adjacent free segments
// concurrency: one operation at a time, new items are stalled until the last result is loaded;
// the segment table has a single read port, shared by the scan, shift and coalesce steps
// reset: asynchronous, active low, one free segment of 1000 units; a pool write reloads it
module first_fit_segment_allocator_top #(
	parameter int MAX_SEGMENTS = 16,
	parameter int SIZE_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  owner_tag,
	input  logic [15:0] request_size,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [3:0]  segment_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] pool_size
);

	ffsa_pkg::dp_cmd_t cmd;
	ffsa_pkg::dp_sts_t sts;

	ffsa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	ffsa_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.SIZE_BITS    (SIZE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.owner_tag     (owner_tag),
		.request_size  (request_size),
		.cfg_data      (pool_size),
		.status        (status),
		.segment_index (segment_index)
	);

endmodule
